[rtl/lpfbc_pkg.sv]
`timescale 1ns / 1ps

package lpfbc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_BATCH_BYTES = 2'd0;
  localparam logic [1:0] CFG_MAX_FRAME_BYTES = 2'd1;
  localparam logic [1:0] CFG_MAX_FRAMES      = 2'd2;

  // register reset values
  localparam logic [15:0] MAX_BATCH_BYTES_RST = 16'd1500;
  localparam logic [15:0] MAX_FRAME_BYTES_RST = 16'd1275;
  localparam logic [7:0]  MAX_FRAMES_RST      = 8'd4;

  // verdict codes
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BATCH_LONG     = 3'd1,
    ST_BAD_COUNT      = 3'd2,
    ST_CUT_PREFIX     = 3'd3,
    ST_ZERO_LEN       = 3'd4,
    ST_FRAME_LONG     = 3'd5,
    ST_OVERRUN        = 3'd6,
    ST_COUNT_MISMATCH = 3'd7
  } status_t;

  // parse phase
  typedef enum logic [2:0] {
    PH_HIGH = 3'b001,
    PH_LOW  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] expected_frames;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  frames_found;
    logic [15:0] batch_bytes;
  } out_t;

  typedef struct packed {
    logic [15:0] max_batch_bytes;
    logic [15:0] max_frame_bytes;
    logic [7:0]  max_frames;
  } cfg_t;

endpackage

[rtl/lpfbc_cfg_regs.sv]
`timescale 1ns / 1ps

module lpfbc_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output lpfbc_pkg::cfg_t    cfg
);
  import lpfbc_pkg::*;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_batch_bytes <= MAX_BATCH_BYTES_RST;
      cfg.max_frame_bytes <= MAX_FRAME_BYTES_RST;
      cfg.max_frames      <= MAX_FRAMES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_BATCH_BYTES: cfg.max_batch_bytes <= cfg_data;
        CFG_MAX_FRAME_BYTES: cfg.max_frame_bytes <= cfg_data;
        CFG_MAX_FRAMES:      cfg.max_frames      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/lpfbc_parser.sv]
`timescale 1ns / 1ps

module lpfbc_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  lpfbc_pkg::in_t     item,
  input  lpfbc_pkg::cfg_t    cfg,
  output lpfbc_pkg::out_t    verdict
);
  import lpfbc_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] body_left, body_left_next;
  logic [16:0] byte_count, byte_count_next;
  logic [7:0]  frame_tally, frame_tally_next;
  logic        tally_over, tally_over_next;
  status_t     first_error, first_error_next;

  logic [15:0] len;
  logic [15:0] body_dec;

  // per-word parse update
  always_comb begin
    phase_next       = phase;
    length_high_next = length_high;
    body_left_next   = body_left;
    frame_tally_next = frame_tally;
    tally_over_next  = tally_over;
    first_error_next = first_error;
    len              = {length_high, item.data_byte};
    body_dec         = (body_left != 16'd0) ? body_left - 16'd1 : body_left;
    byte_count_next  = byte_count[16] ? byte_count : byte_count + 17'd1;

    if (first_error == ST_OK) begin
      unique case (phase)
        PH_LOW: begin
          if (len == 16'd0) begin
            first_error_next = ST_ZERO_LEN;
          end else if (len > cfg.max_frame_bytes) begin
            first_error_next = ST_FRAME_LONG;
          end else begin
            body_left_next = len;
            phase_next     = PH_BODY;
          end
        end
        PH_BODY: begin
          body_left_next = body_dec;
          if (body_dec == 16'd0) begin
            if (frame_tally != 8'hFF) begin
              frame_tally_next = frame_tally + 8'd1;
            end else begin
              tally_over_next = 1'b1;
            end
            phase_next = PH_HIGH;
          end
        end
        default: begin
          length_high_next = item.data_byte;
          phase_next       = PH_LOW;
        end
      endcase
    end
  end

  // verdict from the updated state, priority order
  always_comb begin
    if (byte_count_next > {1'b0, cfg.max_batch_bytes}) begin
      verdict.status = ST_BATCH_LONG;
    end else if (item.expected_frames == 8'd0 ||
                 item.expected_frames > cfg.max_frames) begin
      verdict.status = ST_BAD_COUNT;
    end else if (first_error_next != ST_OK) begin
      verdict.status = first_error_next;
    end else if (phase_next == PH_LOW) begin
      verdict.status = ST_CUT_PREFIX;
    end else if (phase_next == PH_BODY) begin
      verdict.status = ST_OVERRUN;
    end else if (tally_over_next || frame_tally_next != item.expected_frames) begin
      verdict.status = ST_COUNT_MISMATCH;
    end else begin
      verdict.status = ST_OK;
    end
    verdict.frames_found = frame_tally_next;
    verdict.batch_bytes  = byte_count_next[16] ? 16'hFFFF : byte_count_next[15:0];
  end

  // batch state, cleared after each verdict
  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      phase       <= PH_HIGH;
      length_high <= 8'd0;
      body_left   <= 16'd0;
      byte_count  <= 17'd0;
      frame_tally <= 8'd0;
      tally_over  <= 1'b0;
      first_error <= ST_OK;
    end else if (step) begin
      phase       <= phase_next;
      length_high <= length_high_next;
      body_left   <= body_left_next;
      byte_count  <= byte_count_next;
      frame_tally <= frame_tally_next;
      tally_over  <= tally_over_next;
      first_error <= first_error_next;
    end
  end

  // a closed batch leaves a clean state
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> byte_count == 17'd0 && phase == PH_HIGH)
    else $error("batch state not cleared after last word");

  // a framing error sticks until the batch closes
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    first_error != ST_OK && !(step && item.last_byte) |=> $stable(first_error))
    else $error("framing error changed within a batch");

  // in a body there is always at least one byte still to come
  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY && first_error == ST_OK |-> body_left != 16'd0)
    else $error("body phase with nothing left");

  // only length checks raise a framing error
  a_error_kind: assert property (@(posedge clk) disable iff (rst)
    first_error == ST_OK || first_error == ST_ZERO_LEN || first_error == ST_FRAME_LONG)
    else $error("unexpected framing error code");

endmodule

[rtl/length_prefixed_frame_batch_checker.sv]
`timescale 1ns / 1ps
// Length-prefixed frame batch checker.
// Input channel (in_valid/in_ready/in_data) carries one payload byte per word,
// with last_byte marking the end of a batch and expected_frames sampled with
// that last word. Frames are a two-byte big-endian length then the body.
// Output channel (out_valid/out_ready/out_data) carries one verdict word per
// batch: status, frames found and batch length, both saturating.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the
// batch, frame and count limits; write it only while the block is idle.
// Throughput: one word per cycle, save where a stalled receiver holds back a
// last word. Each word goes through an input register and the parse update
// into the result register, from which the verdict of a batch is offered.
// A stalled receiver holds back only a last word that would overwrite a
// waiting verdict; words ahead of it keep flowing, while the input channel
// stays blocked behind the held last word until the verdict is taken.
// Reset restores the default limits, clears the parse state and drops any
// pending word or verdict.
module length_prefixed_frame_batch_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpfbc_pkg::in_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lpfbc_pkg::out_t    out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import lpfbc_pkg::*;

  cfg_t cfg;
  in_t  s1_data;
  logic s1_valid;
  logic s1_step;
  out_t verdict;

  lpfbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // held word moves on unless its verdict has nowhere to go
  assign s1_step  = s1_valid && (!s1_data.last_byte || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  lpfbc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_step),
    .item    (s1_data),
    .cfg     (cfg),
    .verdict (verdict)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_step && s1_data.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && s1_data.last_byte) begin
      out_data <= verdict;
    end
  end

  // a pending verdict is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(s1_step && s1_data.last_byte))
    else $error("verdict overwritten while stalled");

  // a non-last word never waits in the input register
  a_body_flows: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_data.last_byte |-> s1_step)
    else $error("payload word stalled");

  // a last word taken yields a verdict next cycle
  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    s1_step && s1_data.last_byte |=> out_valid)
    else $error("verdict missing after last word");

endmodule
